>>> rtl/nad3_pkg.sv
package nad3_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX_V  = WIDTH_W'(MAX_WIDTH);
  localparam logic [COL_W-1:0]    COL_LAST_V   = COL_W'(MAX_WIDTH - 1);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX_V = HEIGHT_W'(MAX_HEIGHT);

  // front-to-back queue
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int CMD_CNT_W = 2;
  localparam logic [CMD_CNT_W-1:0] CMD_DEPTH_V = 2'd2;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;
  localparam logic [RES_CNT_W-1:0] RES_DEPTH_V = 3'd4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;  // [row][col], row 0 upper, col 0 left

  typedef struct packed {
    pix_t             pixel;
    logic [COL_W-1:0] addr;
    logic             row0;       // first image row: both stores take the pixel
    logic             use_mem;    // drain item or drain row: replicate row above
    logic             first_col;
    logic             emit_a;     // result for the previous column
    logic             emit_b;     // row end: result for the last column
    logic             eof;
  } cmd_t;

  typedef struct packed {
    pix_t center;
    pix_t diff_left;
    pix_t diff_right;
    pix_t diff_up;
    pix_t diff_up_left;
    pix_t diff_up_right;
    pix_t diff_down;
    pix_t diff_down_left;
    pix_t diff_down_right;
    logic last_of_run;
    logic end_of_frame;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_push_t;

endpackage

>>> rtl/nad3_if.sv
interface nad3_pix_if;
  logic                   valid;
  logic                   ready;
  logic [nad3_pkg::PIX_W-1:0] pixel;
  logic                   drain;

  modport source (output valid, pixel, drain, input ready);
  modport sink   (input valid, pixel, drain, output ready);
endinterface

interface nad3_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nad3_pkg::CFG_IDX_W-1:0]  index;
  logic [nad3_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface nad3_res_if;
  logic                       valid;
  logic                       ready;
  logic [nad3_pkg::PIX_W-1:0] center;
  logic [nad3_pkg::PIX_W-1:0] diff_left;
  logic [nad3_pkg::PIX_W-1:0] diff_right;
  logic [nad3_pkg::PIX_W-1:0] diff_up;
  logic [nad3_pkg::PIX_W-1:0] diff_up_left;
  logic [nad3_pkg::PIX_W-1:0] diff_up_right;
  logic [nad3_pkg::PIX_W-1:0] diff_down;
  logic [nad3_pkg::PIX_W-1:0] diff_down_left;
  logic [nad3_pkg::PIX_W-1:0] diff_down_right;
  logic                       last_of_run;
  logic                       end_of_frame;

  modport source (output valid, center, diff_left, diff_right, diff_up, diff_up_left,
                  diff_up_right, diff_down, diff_down_left, diff_down_right,
                  last_of_run, end_of_frame, input ready);
  modport sink   (input valid, center, diff_left, diff_right, diff_up, diff_up_left,
                  diff_up_right, diff_down, diff_down_left, diff_down_right,
                  last_of_run, end_of_frame, output ready);
endinterface

>>> rtl/nad3_front.sv
module nad3_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  nad3_pix_if.sink         pix_i,
  nad3_cfg_if.sink         cfg_i,
  input  logic             cmd_full_i,
  output logic             cmd_push_o,
  output nad3_pkg::cmd_t   cmd_o
);

  logic [nad3_pkg::WIDTH_W-1:0]  width_q;
  logic [nad3_pkg::HEIGHT_W-1:0] height_q;
  logic [nad3_pkg::COL_W-1:0]    col_q, col_d;
  logic [nad3_pkg::ROW_W-1:0]    row_q, row_d;

  logic [nad3_pkg::WIDTH_W-1:0]  width_m1;
  logic [nad3_pkg::COL_W-1:0]    col_last;
  logic [nad3_pkg::HEIGHT_W-1:0] eff_height;
  logic accept, skip, last_col, row0, drain_row;
  logic cfg_we, cfg_hit;

  // out-of-range sizes are clamped
  assign width_m1 = width_q - 1'b1;
  always_comb begin
    if (width_q == '0) begin
      col_last = '0;
    end else if (width_q > nad3_pkg::WIDTH_MAX_V) begin
      col_last = nad3_pkg::COL_LAST_V;
    end else begin
      col_last = width_m1[nad3_pkg::COL_W-1:0];
    end
    if (height_q == '0) begin
      eff_height = 13'd1;
    end else if (height_q > nad3_pkg::HEIGHT_MAX_V) begin
      eff_height = nad3_pkg::HEIGHT_MAX_V;
    end else begin
      eff_height = height_q;
    end
  end

  assign pix_i.ready = !cmd_full_i;
  assign accept      = pix_i.valid && pix_i.ready;

  assign row0      = (row_q == '0);
  assign drain_row = (row_q == eff_height);
  assign last_col  = (col_q == col_last);
  // drain items before the second row carry nothing
  assign skip      = row0 && pix_i.drain;

  assign cmd_push_o = accept && !skip;

  always_comb begin
    cmd_o.pixel     = pix_i.pixel;
    cmd_o.addr      = col_q;
    cmd_o.row0      = row0;
    cmd_o.use_mem   = drain_row || pix_i.drain;
    cmd_o.first_col = (col_q == '0);
    cmd_o.emit_a    = !row0 && (col_q != '0);
    cmd_o.emit_b    = !row0 && last_col;
    cmd_o.eof       = drain_row;
  end

  always_comb begin
    col_d = col_q + 1'b1;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = drain_row ? '0 : row_q + 1'b1;
    end
  end

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_comb begin
    unique case (cfg_i.index)
      nad3_pkg::CFG_FRAME_WIDTH,
      nad3_pkg::CFG_FRAME_HEIGHT: cfg_hit = 1'b1;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= nad3_pkg::RESET_WIDTH;
      height_q <= nad3_pkg::RESET_HEIGHT;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we && cfg_hit) begin
      if (cfg_i.index == nad3_pkg::CFG_FRAME_WIDTH) begin
        width_q <= cfg_i.data[nad3_pkg::WIDTH_W-1:0];
      end else begin
        height_q <= cfg_i.data[nad3_pkg::HEIGHT_W-1:0];
      end
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> rtl/nad3_cmd_queue.sv
module nad3_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nad3_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  output nad3_pkg::cmd_t data_o,
  input  logic           pop_i
);

  nad3_pkg::cmd_t                 entry_q [nad3_pkg::CMD_DEPTH];
  logic [nad3_pkg::CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [nad3_pkg::CMD_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == nad3_pkg::CMD_DEPTH_V);
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

>>> rtl/nad3_back.sv
module nad3_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  nad3_pkg::cmd_t                  cmd_i,
  output logic                            cmd_pop_o,
  input  logic [nad3_pkg::RES_CNT_W-1:0]  res_free_i,
  output nad3_pkg::res_push_t             res_push_o
);

  function automatic nad3_pkg::pix_t abs_diff(nad3_pkg::pix_t a, nad3_pkg::pix_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic nad3_pkg::res_t make_res(nad3_pkg::win_t w);
    nad3_pkg::res_t r;
    nad3_pkg::pix_t c;
    c                 = w[1][1];
    r.center          = c;
    r.diff_left       = abs_diff(c, w[1][0]);
    r.diff_right      = abs_diff(c, w[1][2]);
    r.diff_up         = abs_diff(c, w[0][1]);
    r.diff_up_left    = abs_diff(c, w[0][0]);
    r.diff_up_right   = abs_diff(c, w[0][2]);
    r.diff_down       = abs_diff(c, w[2][1]);
    r.diff_down_left  = abs_diff(c, w[2][0]);
    r.diff_down_right = abs_diff(c, w[2][2]);
    r.last_of_run     = 1'b0;
    r.end_of_frame    = 1'b0;
    return r;
  endfunction

  nad3_pkg::pix_t up_mem  [nad3_pkg::MAX_WIDTH];
  nad3_pkg::pix_t mid_mem [nad3_pkg::MAX_WIDTH];
  nad3_pkg::pix_t up_rd_q, mid_rd_q;

  logic           exe_valid_q;
  nad3_pkg::cmd_t exe_q;
  nad3_pkg::win_t win_q, win1, win2;

  nad3_pkg::pix_t a, b, n, up_wdata;
  nad3_pkg::pix_t col_v [3];
  nad3_pkg::res_t res_a, res_b;
  logic [1:0]     push_cnt;
  logic           adv, fwd;

  // execute stage: store data read on the hand-off edge is in up_rd_q/mid_rd_q
  assign push_cnt = {1'b0, exe_q.emit_a} + {1'b0, exe_q.emit_b};
  assign adv      = exe_valid_q && ({1'b0, push_cnt} <= res_free_i);
  assign cmd_pop_o = cmd_valid_i && (!exe_valid_q || adv);
  // same column back to back (one-pixel rows): take the value being written
  assign fwd      = adv && (cmd_i.addr == exe_q.addr);

  always_comb begin
    n        = exe_q.use_mem ? mid_rd_q : exe_q.pixel;
    a        = exe_q.row0 ? n : up_rd_q;
    b        = exe_q.row0 ? n : mid_rd_q;
    up_wdata = b;
    col_v[0] = a;
    col_v[1] = b;
    col_v[2] = n;
    for (int i = 0; i < 3; i++) begin
      if (exe_q.first_col) begin
        win1[i][0] = col_v[i];
        win1[i][1] = col_v[i];
        win1[i][2] = col_v[i];
      end else begin
        win1[i][0] = win_q[i][1];
        win1[i][1] = win_q[i][2];
        win1[i][2] = col_v[i];
      end
      // right border: replicate the last column
      win2[i][0] = win1[i][1];
      win2[i][1] = win1[i][2];
      win2[i][2] = win1[i][2];
    end
  end

  always_comb begin
    res_a = make_res(win1);
    res_b = make_res(win2);
    res_b.last_of_run  = 1'b1;
    res_b.end_of_frame = exe_q.eof;

    res_push_o.cnt = adv ? push_cnt : 2'd0;
    if (exe_q.emit_a) begin
      res_push_o.r0 = res_a;
      res_push_o.r0.last_of_run = !exe_q.emit_b;
      res_push_o.r1 = res_b;
    end else begin
      res_push_o.r0 = res_b;
      res_push_o.r1 = res_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      up_mem[exe_q.addr]  <= up_wdata;
      mid_mem[exe_q.addr] <= n;
    end
    if (cmd_pop_o) begin
      up_rd_q  <= fwd ? up_wdata : up_mem[cmd_i.addr];
      mid_rd_q <= fwd ? n : mid_mem[cmd_i.addr];
      exe_q    <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exe_valid_q <= 1'b0;
      win_q       <= '0;
    end else begin
      if (cmd_pop_o) begin
        exe_valid_q <= 1'b1;
      end else if (adv) begin
        exe_valid_q <= 1'b0;
      end
      if (adv) begin
        win_q <= exe_q.emit_b ? win2 : win1;
      end
    end
  end

endmodule

>>> rtl/nad3_res_queue.sv
module nad3_res_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nad3_pkg::res_push_t            push_i,
  output logic [nad3_pkg::RES_CNT_W-1:0] free_o,
  nad3_res_if.source                     res_o
);

  nad3_pkg::res_t                 entry_q [nad3_pkg::RES_DEPTH];
  logic [nad3_pkg::RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [nad3_pkg::RES_CNT_W-1:0] cnt_q;
  nad3_pkg::res_t                 head;
  logic                           pop;

  assign free_o    = nad3_pkg::RES_DEPTH_V - cnt_q;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign head      = entry_q[rd_ptr_q];
  assign pop       = res_o.valid && res_o.ready;

  assign res_o.valid           = (cnt_q != '0);
  assign res_o.center          = head.center;
  assign res_o.diff_left       = head.diff_left;
  assign res_o.diff_right      = head.diff_right;
  assign res_o.diff_up         = head.diff_up;
  assign res_o.diff_up_left    = head.diff_up_left;
  assign res_o.diff_up_right   = head.diff_up_right;
  assign res_o.diff_down       = head.diff_down;
  assign res_o.diff_down_left  = head.diff_down_left;
  assign res_o.diff_down_right = head.diff_down_right;
  assign res_o.last_of_run     = head.last_of_run;
  assign res_o.end_of_frame    = head.end_of_frame;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.cnt;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {1'b0, push_i.cnt} - {2'b00, pop};
    end
  end

endmodule

>>> rtl/neighbourhood_abs_difference_3x3.sv
// 3x3 neighbourhood absolute differences over an 8-bit gray raster stream with
// replicated borders. One request is taken per clock. The front counts column
// and row and tags each request; a two-entry queue hands it to the back end,
// which reads both 1024-entry line stores on the hand-off edge and builds the
// window and the eight differences in the cycle after it. The result for pixel
// (r-1, c-1) comes out with request (r, c); a row end adds the last column's
// result, so every row after the first yields as many results as requests
// (none on the first column, two on the last). The block keeps one request per
// clock as long as the result port takes one result per clock; the input
// stalls only when results back up. Results pass the execute register and the
// result queue before they are presented. After the last image row, send one
// drain request per column; drain requests in the first row are dropped.
// Writing frame_width or frame_height restarts the frame; write only while idle.
module neighbourhood_abs_difference_3x3 (
  input  logic       clk_i,
  input  logic       rst_ni,
  nad3_pix_if.sink   pix_i,
  nad3_cfg_if.sink   cfg_i,
  nad3_res_if.source res_o
);

  logic                           cmd_push, cmd_full, cmd_valid, cmd_pop;
  nad3_pkg::cmd_t                 cmd_wr, cmd_rd;
  nad3_pkg::res_push_t            res_push;
  logic [nad3_pkg::RES_CNT_W-1:0] res_free;

  nad3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_i),
    .cfg_i      (cfg_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  nad3_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_wr),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .data_o  (cmd_rd),
    .pop_i   (cmd_pop)
  );

  nad3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .res_free_i  (res_free),
    .res_push_o  (res_push)
  );

  nad3_res_queue u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .free_o (res_free),
    .res_o  (res_o)
  );

`ifndef NO_ASSERTIONS
  a_push_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (pix_i.valid && pix_i.ready))
    else $error("front pushed without an accepted request");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back end popped an empty queue");

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, res_push.cnt} <= res_free))
    else $error("result queue overflow");

  a_eof_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.end_of_frame) |-> res_o.last_of_run)
    else $error("end of frame not on the last result of its request");
`endif

endmodule

>>> bench/tb_neighbourhood_abs_difference_3x3.sv
module tb_neighbourhood_abs_difference_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  import nad3_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 160;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;  // unmapped index, no effect

  class diff_scoreboard;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    pix_t                upper_line [MAX_WIDTH];
    pix_t                middle_line [MAX_WIDTH];
    pix_t                win [3][3];  // [row][col], row 0 upper, col 0 left
    int unsigned         col;
    int unsigned         row;
    res_t                expected_res [$];
    int unsigned         mismatches;

    function new();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col        = 0;
      row        = 0;
      mismatches = 0;
    endfunction

    function int unsigned frame_cols();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function int unsigned frame_rows();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(height_reg);
    endfunction

    function int unsigned pending();
      return expected_res.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH) width_reg = data[WIDTH_W-1:0];
      else if (idx == CFG_FRAME_HEIGHT) height_reg = data[HEIGHT_W-1:0];
      else return;
      col = 0;
      row = 0;
    endfunction

    function pix_t abs_gap(pix_t x, pix_t y);
      return (x > y) ? pix_t'(x - y) : pix_t'(y - x);
    endfunction

    function void shift_column(pix_t a, pix_t b, pix_t n);
      pix_t v [3];
      v = '{a, b, n};
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
        win[i][2] = v[i];
      end
    endfunction

    function res_t window_result();
      res_t r;
      pix_t c;
      c                 = win[1][1];
      r.center          = c;
      r.diff_left       = abs_gap(c, win[1][0]);
      r.diff_right      = abs_gap(c, win[1][2]);
      r.diff_up         = abs_gap(c, win[0][1]);
      r.diff_up_left    = abs_gap(c, win[0][0]);
      r.diff_up_right   = abs_gap(c, win[0][2]);
      r.diff_down       = abs_gap(c, win[2][1]);
      r.diff_down_left  = abs_gap(c, win[2][0]);
      r.diff_down_right = abs_gap(c, win[2][2]);
      r.last_of_run     = 1'b0;
      r.end_of_frame    = 1'b0;
      return r;
    endfunction

    // Advances the window by one accepted request and queues the results it causes.
    function void take_pixel(pix_t pixel, logic drain);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      pix_t        a;
      pix_t        b;
      pix_t        n;
      res_t        outs [$];
      res_t        r;
      w = frame_cols();
      h = frame_rows();
      c = col;
      if (c >= w) c = w - 1;
      if (row > h) row = h;
      if (row == 0 && drain) return;

      n = (row >= h || drain) ? middle_line[c] : pixel;
      if (row == 0) begin
        a = n;
        b = n;
        upper_line[c]  = n;
        middle_line[c] = n;
      end else begin
        a = upper_line[c];
        b = middle_line[c];
        upper_line[c]  = b;
        middle_line[c] = n;
      end

      if (c == 0) begin
        for (int j = 0; j < 3; j++) begin
          win[0][j] = a;
          win[1][j] = b;
          win[2][j] = n;
        end
      end else begin
        shift_column(a, b, n);
      end

      if (row >= 1 && c >= 1) outs.push_back(window_result());

      if (c == w - 1) begin
        // right border: replicate the last column once more
        if (row >= 1) begin
          shift_column(win[0][2], win[1][2], win[2][2]);
          r = window_result();
          r.end_of_frame = (row == h);
          outs.push_back(r);
        end
        col = 0;
        row = (row >= h) ? 0 : row + 1;
      end else begin
        col = c + 1;
      end

      if (outs.size() > 0) begin
        r = outs.pop_back();
        r.last_of_run = 1'b1;
        outs.push_back(r);
      end
      foreach (outs[i]) expected_res.push_back(outs[i]);
    endfunction

    function string describe(res_t r);
      return $sformatf({"c=%0d l=%0d r=%0d u=%0d ul=%0d ur=%0d d=%0d dl=%0d dr=%0d",
                        " last=%0b eof=%0b"},
                       r.center, r.diff_left, r.diff_right, r.diff_up, r.diff_up_left,
                       r.diff_up_right, r.diff_down, r.diff_down_left, r.diff_down_right,
                       r.last_of_run, r.end_of_frame);
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string bad;
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing pending: %s", $realtime, describe(got));
        return;
      end
      want = expected_res.pop_front();
      bad  = "";
      if (got.center !== want.center) bad = {bad, " center"};
      if (got.diff_left !== want.diff_left) bad = {bad, " diff_left"};
      if (got.diff_right !== want.diff_right) bad = {bad, " diff_right"};
      if (got.diff_up !== want.diff_up) bad = {bad, " diff_up"};
      if (got.diff_up_left !== want.diff_up_left) bad = {bad, " diff_up_left"};
      if (got.diff_up_right !== want.diff_up_right) bad = {bad, " diff_up_right"};
      if (got.diff_down !== want.diff_down) bad = {bad, " diff_down"};
      if (got.diff_down_left !== want.diff_down_left) bad = {bad, " diff_down_left"};
      if (got.diff_down_right !== want.diff_down_right) bad = {bad, " diff_down_right"};
      if (got.last_of_run !== want.last_of_run) bad = {bad, " last_of_run"};
      if (got.end_of_frame !== want.end_of_frame) bad = {bad, " end_of_frame"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch in%s", $realtime, bad);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nad3_pix_if pix_if ();
  nad3_cfg_if cfg_if ();
  nad3_res_if res_if ();

  neighbourhood_abs_difference_3x3 uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  diff_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned cycles;
  res_t        seen;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result-side ready, with one long hold-off on request to back up the pipeline
  initial begin
    res_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen = '{center: res_if.center, diff_left: res_if.diff_left,
               diff_right: res_if.diff_right, diff_up: res_if.diff_up,
               diff_up_left: res_if.diff_up_left, diff_up_right: res_if.diff_up_right,
               diff_down: res_if.diff_down, diff_down_left: res_if.diff_down_left,
               diff_down_right: res_if.diff_down_right, last_of_run: res_if.last_of_run,
               end_of_frame: res_if.end_of_frame};
      sb.check_result(seen);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic pix_t any_pixel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_pix(input pix_t p, input logic d);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.pixel = p;
    pix_if.drain = d;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    sb.take_pixel(p, d);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    pix_if.valid = 1'b0;
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Waits until no expected result is pending, then leaves time after the last one.
  task automatic settle();
    pix_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Raster frames plus the drain row, with stray drains mixed in; the last frame
  // may be cut short when the budget runs out.
  task automatic send_frames(input int unsigned budget);
    int unsigned w;
    int unsigned h;
    int unsigned sent;
    logic        drn;
    w    = sb.frame_cols();
    h    = sb.frame_rows();
    sent = 0;
    while (sent < budget) begin
      for (int unsigned r = 0; r <= h && sent < budget; r++) begin
        for (int unsigned c = 0; c < w && sent < budget; c++) begin
          if (r == 0 && $urandom_range(0, 99) < 6) send_pix(any_pixel(), 1'b1);
          if (r == h) drn = ($urandom_range(0, 99) < 75);
          else if (r > 0) drn = ($urandom_range(0, 99) < 10);
          else drn = 1'b0;
          send_pix(any_pixel(), drn);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv,
                           input int unsigned budget);
    write_reg(CFG_FRAME_WIDTH, wv);
    write_reg(CFG_FRAME_HEIGHT, hv);
    send_frames(budget);
    settle();
  endtask

  task automatic random_phase();
    logic [CFG_DATA_W-1:0] wv;
    if ($urandom_range(0, 99) < 20) wv = CFG_DATA_W'($urandom_range(9, 40));
    else wv = CFG_DATA_W'($urandom_range(0, 8));
    run_phase(wv, CFG_DATA_W'($urandom_range(0, 6)), 50);
  endtask

  initial begin
    pix_if.valid  = 1'b0;
    pix_if.pixel  = '0;
    pix_if.drain  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_FRAME_WIDTH;
    cfg_if.data   = '0;
    rst_ni        = 1'b0;
    hold_req      = 1'b0;
    src_idle_pct  = 27;
    sink_idle_pct = 73;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(negedge clk_i);

    // single pixel image; first drain is dropped, pixel in drain row is ignored
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    write_reg(CFG_SPARE, 13'h1FFF);
    send_pix(8'h5A, 1'b1);
    send_pix(8'h00, 1'b0);
    send_pix(8'hFF, 1'b0);
    settle();

    // 3x2 with extremes, a drain inside the image and a pixel in the drain row
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    send_pix(8'hFF, 1'b0);
    send_pix(8'h00, 1'b0);
    send_pix(8'hFF, 1'b0);
    send_pix(8'h00, 1'b0);
    send_pix(8'h33, 1'b1);
    send_pix(8'hFF, 1'b0);
    send_pix(8'h00, 1'b1);
    send_pix(8'hC8, 1'b0);
    send_pix(8'h00, 1'b1);
    settle();

    // zero width and height act as one
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    send_pix(8'hFF, 1'b0);
    send_pix(8'h00, 1'b1);
    settle();

    // over-range width clamps to the full line store
    run_phase(13'h1FFF, 13'd1, 40);
    random_phase();
    random_phase();

    src_idle_pct  = 73;
    sink_idle_pct = 27;
    run_phase(13'd3, 13'h1FFF, 60);
    random_phase();
    random_phase();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = 1'b1;
    random_phase();
    random_phase();
    run_phase(CFG_DATA_W'(MAX_WIDTH), CFG_DATA_W'(MAX_HEIGHT), 30);

    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
